// ===== sv/qass_pkg.sv =====
// Package with the character codes and state types of the quote-aware space-strip filter.
package qass_pkg;

  // Character codes that the filter recognizes or produces.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Flags that carry the literal tracking from one character to the next.
  typedef struct packed {
    logic inside_literal;
    logic literal_is_double;
    logic previous_was_backslash;
    logic just_closed;
  } lit_state_t;

endpackage

// ===== sv/quote_aware_space_strip_filter.sv =====
// Top level of the quote-aware space-strip filter.
//
// The input channel (in_valid, in_stall, in_char, in_last) takes one character per
// request; in_last marks the final character of a sentence. The result channel
// (res_valid, res_stall, out_char, out_valid, out_last) returns zero or one result
// per character: out_valid is 1 when a character is emitted, and a dropped final
// character still yields one result with out_valid 0 and out_last 1.
// The strip_escapes register is written through cfg_valid, cfg_ready and cfg_data;
// cfg_ready is high while no character is held inside the block.
// A character is captured in the input register; from there it is evaluated against
// the literal flags and its result is loaded into the result register.
// Throughput is one character per cycle while no result waits under res_stall; the
// flag update is a few gates deep, and the state loop runs through the flag register.
// When res_stall is high while a result is waiting, the result register holds, and
// in_stall rises once the input register holds a character that produces a result.
// Characters that produce no result keep draining during a stall.
// Synchronous reset clears the literal flags, both valid bits and strip_escapes.
module quote_aware_space_strip_filter (
  input  logic       clk,
  input  logic       rst,
  // Input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last,
  // Result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_char,
  output logic       out_valid,
  output logic       out_last,
  // Configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import qass_pkg::*;

  logic       strip_escapes;
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  lit_state_t st;
  lit_state_t st_next;
  logic       emit;
  logic [7:0] emit_char;
  logic       has_result;
  logic       s1_consume;
  logic       in_take;
  logic [7:0] close_quote;

  // Configuration is accepted only when nothing is in flight.
  assign cfg_ready = !s1_valid && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_escapes <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      strip_escapes <= cfg_data;
    end
  end

  // The held character leaves when it makes no result or the result register is free.
  assign s1_consume = s1_valid && (!has_result || !res_valid || !res_stall);
  assign in_stall   = s1_valid && !s1_consume;
  assign in_take    = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char <= in_char;
      s1_last <= in_last;
    end
  end

  assign close_quote = st.literal_is_double ? CH_DQUOTE : CH_SQUOTE;

  // Character classification and next literal flags.
  always_comb begin
    emit      = 1'b0;
    emit_char = CH_NUL;
    st_next   = st;
    if (st.inside_literal) begin
      st_next.previous_was_backslash = (s1_char == CH_BSLASH);
      if (!strip_escapes && s1_char == CH_RPAREN) begin
        emit      = 1'b1;
        emit_char = CH_RBRACK;
      end else if (!strip_escapes && s1_char == CH_LPAREN) begin
        emit      = 1'b1;
        emit_char = CH_LBRACK;
      end else if (s1_char == close_quote && !st.previous_was_backslash) begin
        st_next.inside_literal         = 1'b0;
        st_next.previous_was_backslash = 1'b0;
        if (strip_escapes) begin
          st_next.just_closed = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_char = s1_char;
        end
      end else if (s1_char == CH_BSLASH) begin
        emit      = !strip_escapes;
        emit_char = strip_escapes ? CH_NUL : s1_char;
      end else begin
        emit      = 1'b1;
        emit_char = s1_char;
      end
    end else if (st.just_closed) begin
      // The character after a closing quote is never taken as a new quote.
      st_next.just_closed = 1'b0;
      if (s1_char != CH_SPACE) begin
        emit      = 1'b1;
        emit_char = s1_char;
      end
    end else if (s1_char == CH_SQUOTE || s1_char == CH_DQUOTE) begin
      st_next.inside_literal         = 1'b1;
      st_next.literal_is_double      = (s1_char == CH_DQUOTE);
      st_next.previous_was_backslash = 1'b0;
      emit      = !strip_escapes;
      emit_char = strip_escapes ? CH_NUL : s1_char;
    end else if (s1_char != CH_SPACE) begin
      emit      = 1'b1;
      emit_char = s1_char;
    end
    // The end of a sentence starts the next one from a clean state.
    if (s1_last) begin
      st_next = '0;
    end
  end

  assign has_result = emit || s1_last;

  // Literal flags advance once per consumed character.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_consume) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_consume && has_result) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_consume && has_result) begin
      out_char  <= emit_char;
      out_valid <= emit;
      out_last  <= s1_last;
    end
  end

endmodule

// ===== sv/qass_checker.sv =====
// Port-level checker for the quote-aware space-strip filter, with its bind.
module qass_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_char,
  input logic       out_valid,
  input logic       out_last
);
  import qass_pkg::*;

  // Every result either carries a character or closes a sentence.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (out_valid || out_last))
    else $error("result with neither a character nor an end mark");

  // A result without a character shows the NUL code.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> (out_char == CH_NUL))
    else $error("empty result carries a nonzero character");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(out_char)
      && $stable(out_valid) && $stable(out_last)))
    else $error("stalled result changed");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result present right after reset");

endmodule

bind quote_aware_space_strip_filter qass_checker u_qass_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .out_char  (out_char),
  .out_valid (out_valid),
  .out_last  (out_last)
);

// ===== tb/sv/quote_aware_space_strip_filter_tb.sv =====
// Testbench for the quote-aware space-strip filter: a directed table, then random sentences.
`timescale 1ns / 100ps

module quote_aware_space_strip_filter_tb;
  import qass_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT = 4000;
  localparam int SEGMENT_CHARS = 305;
  localparam int MAX_SHOWN = 40;

  // One filtered character as it leaves the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       v;
    logic       l;
  } filt_res_t;

  // One row of the directed table.
  typedef struct {
    bit         strip;
    logic [7:0] ch;
    bit         last;
    bit         fixed;
    bit         has;
    filt_res_t  res;
  } plan_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char;
  logic       in_last;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_valid;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  // Typed-in expectation that travels with the current request.
  bit         fx_on;
  bit         fx_has;
  filt_res_t  fx_res;

  // Predictor state and expected results.
  lit_state_t lit_flags;
  bit         strip_mode;
  filt_res_t  expected_chars[$];
  plan_row_t  plan[$];

  int tx_idle_pct = 8;
  int rx_idle_pct = 68;
  int err_count = 0;
  int chars_in = 0;
  int results_out = 0;
  int dropped_finals = 0;

  quote_aware_space_strip_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char),
    .in_last   (in_last),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_char  (out_char),
    .out_valid (out_valid),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Filters one character against the literal flags and the current mode.
  function automatic void filter_char(input logic [7:0] ch, input logic last,
                                      output bit has, output filt_res_t r);
    logic [7:0] q;
    logic [7:0] oc;
    bit was_bs;
    bit emit;
    emit = 1'b0;
    oc = CH_NUL;
    if (lit_flags.inside_literal) begin
      q = lit_flags.literal_is_double ? CH_DQUOTE : CH_SQUOTE;
      was_bs = lit_flags.previous_was_backslash;
      lit_flags.previous_was_backslash = (ch == CH_BSLASH);
      if (!strip_mode && ch == CH_RPAREN) begin
        emit = 1'b1;
        oc = CH_RBRACK;
      end else if (!strip_mode && ch == CH_LPAREN) begin
        emit = 1'b1;
        oc = CH_LBRACK;
      end else if (ch == q && !was_bs) begin
        lit_flags.inside_literal = 1'b0;
        lit_flags.previous_was_backslash = 1'b0;
        if (strip_mode) begin
          lit_flags.just_closed = 1'b1;
        end else begin
          emit = 1'b1;
          oc = ch;
        end
      end else if (ch == CH_BSLASH) begin
        if (!strip_mode) begin
          emit = 1'b1;
          oc = ch;
        end
      end else begin
        emit = 1'b1;
        oc = ch;
      end
    end else if (lit_flags.just_closed) begin
      // The character after a closing quote is copied as it stands, unless it is a space.
      lit_flags.just_closed = 1'b0;
      if (ch != CH_SPACE) begin
        emit = 1'b1;
        oc = ch;
      end
    end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
      lit_flags.inside_literal = 1'b1;
      lit_flags.literal_is_double = (ch == CH_DQUOTE);
      lit_flags.previous_was_backslash = 1'b0;
      if (!strip_mode) begin
        emit = 1'b1;
        oc = ch;
      end
    end else if (ch != CH_SPACE) begin
      emit = 1'b1;
      oc = ch;
    end
    if (last) begin
      lit_flags = '0;
    end
    has = emit || last;
    r.ch = emit ? oc : CH_NUL;
    r.v = emit;
    r.l = last;
  endfunction

  // Prints one mismatch line, up to a cap, and counts it.
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    if (err_count <= MAX_SHOWN) begin
      $display("%0t: %s: got %02h, expected %02h", $time, what, got, want);
    end
  endtask

  // Picks a character with quotes, backslashes, parentheses and spaces made common.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return CH_SPACE;
    if (r < 32) return CH_SQUOTE;
    if (r < 44) return CH_DQUOTE;
    if (r < 54) return CH_BSLASH;
    if (r < 60) return CH_LPAREN;
    if (r < 66) return CH_RPAREN;
    if (r < 69) return ($urandom_range(0, 1) == 0) ? CH_NUL : 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Appends one row to the directed table.
  task automatic add_row(input bit strip, input logic [7:0] ch, input bit last,
                         input bit fixed, input bit has, input logic [7:0] rc,
                         input bit rv, input bit rl);
    plan_row_t row;
    row.strip = strip;
    row.ch = ch;
    row.last = last;
    row.fixed = fixed;
    row.has = has;
    row.res = '{ch: rc, v: rv, l: rl};
    plan.push_back(row);
  endtask

  // Sends one request, with random idle cycles ahead of it.
  task automatic send_char(input logic [7:0] ch, input logic last, input bit fixed,
                           input bit has, input filt_res_t res);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char <= ch;
    in_last <= last;
    fx_on <= fixed;
    fx_has <= has;
    fx_res <= res;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets the block go idle, then writes the mode register.
  task automatic set_mode(input bit m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stall, redrawn every cycle.
  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Tracks the mode, predicts each accepted request and checks each result.
  always @(posedge clk) begin
    bit has;
    filt_res_t r;
    filt_res_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        strip_mode = cfg_data;
      end
      if (in_valid && !in_stall) begin
        filter_char(in_char, in_last, has, r);
        if (fx_on) begin
          has = fx_has;
          r = fx_res;
        end
        if (has) begin
          expected_chars.push_back(r);
        end
        chars_in++;
      end
      if (res_valid && !res_stall) begin
        results_out++;
        if (out_last && !out_valid) begin
          dropped_finals++;
        end
        if (expected_chars.size() == 0) begin
          report_mismatch("result with nothing expected", out_char, CH_NUL);
        end else begin
          want = expected_chars.pop_front();
          if (out_valid !== want.v) begin
            report_mismatch("out_valid", {7'd0, out_valid}, {7'd0, want.v});
          end
          if (out_last !== want.l) begin
            report_mismatch("out_last", {7'd0, out_last}, {7'd0, want.l});
          end
          if (want.v && out_char !== want.ch) begin
            report_mismatch("out_char", out_char, want.ch);
          end
        end
      end
    end
  end

  // Ends the run when nothing has moved on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (res_valid && !res_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("quote_aware_space_strip_filter test failed");
    $finish;
  end

  // Main sequence: reset, directed table, random sentences, drain and verdict.
  initial begin
    int sent;
    int len;
    bit mode_now;
    rst = 1'b1;
    in_valid = 1'b0;
    in_char = 8'h00;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    fx_on = 1'b0;
    fx_has = 1'b0;
    fx_res = '0;
    lit_flags = '0;
    strip_mode = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Keep mode: spaces, byte extremes, parentheses, escaped quote, dropped final space.
    add_row(0, CH_SPACE,  0, 1, 0, CH_NUL,    0, 0);
    add_row(0, 8'hFF,     0, 1, 1, 8'hFF,     1, 0);
    add_row(0, CH_NUL,    0, 1, 1, CH_NUL,    1, 0);
    add_row(0, CH_DQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(0, CH_LPAREN, 0, 1, 1, CH_LBRACK, 1, 0);
    add_row(0, CH_RPAREN, 0, 1, 1, CH_RBRACK, 1, 0);
    add_row(0, CH_SPACE,  0, 0, 0, CH_NUL,    0, 0);
    add_row(0, CH_BSLASH, 0, 0, 0, CH_NUL,    0, 0);
    add_row(0, CH_DQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(0, CH_DQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(0, CH_SPACE,  1, 1, 1, CH_NUL,    0, 1);
    // Keep mode: a quote after two backslashes, then the sentence ends inside the literal.
    add_row(0, CH_SQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(0, CH_BSLASH, 0, 0, 0, CH_NUL,    0, 0);
    add_row(0, CH_BSLASH, 0, 0, 0, CH_NUL,    0, 0);
    add_row(0, CH_SQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(0, 8'h41,     1, 0, 0, CH_NUL,    0, 0);
    // Strip mode: unescaped quotes and backslashes dropped, the character after a close copied.
    add_row(1, CH_SQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(1, CH_LPAREN, 0, 0, 0, CH_NUL,    0, 0);
    add_row(1, CH_BSLASH, 0, 0, 0, CH_NUL,    0, 0);
    add_row(1, CH_SQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(1, CH_SQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(1, CH_DQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(1, CH_SPACE,  0, 0, 0, CH_NUL,    0, 0);
    add_row(1, CH_DQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    add_row(1, CH_DQUOTE, 0, 0, 0, CH_NUL,    0, 0);
    // Back to keep mode while a close is still pending.
    add_row(0, 8'h7E,     1, 0, 0, CH_NUL,    0, 0);

    set_mode(1'b0);
    mode_now = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].strip != mode_now) begin
        set_mode(plan[i].strip);
        mode_now = plan[i].strip;
      end
      send_char(plan[i].ch, plan[i].last, plan[i].fixed, plan[i].has, plan[i].res);
    end

    // Random sentences under three idling profiles, each in both modes.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 68 : 0;
      rx_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 8 : 0;
      for (int m = 1; m >= 0; m--) begin
        set_mode(m[0]);
        sent = 0;
        while (sent < SEGMENT_CHARS) begin
          if ($urandom_range(0, 99) < 12) begin
            // Noise: any byte, with the final marker now and then.
            send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0), 0, 0, '0);
            sent++;
          end else begin
            len = $urandom_range(1, 14);
            for (int k = 0; k < len; k++) begin
              send_char(pick_char(), (k == len - 1), 0, 0, '0);
              sent++;
            end
          end
        end
      end
    end

    // Drain what is still in flight.
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Sent %0d characters in keep and strip modes; checked %0d results.",
             chars_in, results_out);
    $display("Dropped final characters seen: %0d; mismatches: %0d.",
             dropped_finals, err_count);
    if (err_count == 0) begin
      $display("quote_aware_space_strip_filter test passed");
    end else begin
      $display("quote_aware_space_strip_filter test failed");
    end
    $finish;
  end

endmodule
